>>> hdl/rws_pkg.sv
// Shared constants, types and helpers for the roulette wheel selector.
// No dependencies; imported by rws_alu and roulette_wheel_selector.
`timescale 1ns / 1ps

package rws_pkg;

	// population size and the widths that follow from it
	localparam int POP_MAX   = 256;
	localparam int IDX_W     = (POP_MAX > 2) ? $clog2(POP_MAX) : 1;
	localparam int CNT_W     = $clog2(POP_MAX + 1);

	// field widths
	localparam int FIT_W     = 32;
	localparam int FRAC_W    = 33;
	localparam int OUT_IDX_W = 8;

	// running sums reach POP_MAX * 2^32, one spare bit gives the adder a sign
	localparam int PFX_W     = FIT_W + CNT_W;
	localparam int ALU_W     = PFX_W + 1;

	// serial multiplier walks the low 32 bits of the fraction
	localparam int MUL_STEPS = 32;
	localparam int MCNT_W    = $clog2(MUL_STEPS);

	localparam logic [FRAC_W-1:0] FRAC_ONE   = FRAC_W'(64'h1_0000_0000);
	localparam logic [FIT_W-1:0]  FIT_MAX    = FIT_W'(32'h7FFF_FFFF);
	// one LSB of Q16.16 keeps every weight above zero
	localparam logic              WEIGHT_LSB = 1'b1;

	// opcodes of an input beat
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	// operand set for the shared adder
	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             inv_b;
		logic             cin;
	} alu_req_t;

	function automatic logic [ALU_W-1:0] sext_fit(input logic [FIT_W-1:0] v);
		sext_fit = {{(ALU_W - FIT_W){v[FIT_W-1]}}, v};
	endfunction

endpackage

>>> hdl/roulette_wheel_selector.sv
// Roulette wheel selector top level: sequencer, fitness and prefix memories.
// Depends on rws_pkg and rws_alu.
`timescale 1ns / 1ps

// Fitness-proportionate selection over a population of up to POP_MAX signed
// Q16.16 fitness values. A load beat (operation = 0) stores one value; values
// past POP_MAX are dropped. A load with last set closes the population: the
// block scans the store once for the minimum, then builds running sums of
// (fitness - minimum + 1 LSB) with a subtract step and an add step per entry
// through the one shared adder. A draw beat (operation = 1) carries r scaled
// by 2^32, saturated to 1.0. It reads the total, forms floor(r * total / 2^32)
// with a shift-add multiplier on the same adder, then scans the running sums
// one entry per cycle and returns the first index whose sum reaches the
// threshold. A draw while no population is closed returns found = 0. Loads
// produce no result beat. Input stall stays high whenever the sequencer is
// busy; one result register lets a finished draw wait on the output while
// the next beat is taken. The memories need no clearing after reset.

module roulette_wheel_selector import rws_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 operation,
	input  logic signed [FIT_W-1:0] fitness,
	input  logic                 last,
	input  logic [FRAC_W-1:0]    random_fraction,

	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [OUT_IDX_W-1:0] chosen_index,
	output logic                 found
);

	typedef enum logic [8:0] {
		S_IDLE    = 9'b0_0000_0001,
		S_MIN     = 9'b0_0000_0010,
		S_PFX_RD  = 9'b0_0000_0100,
		S_PFX_SUB = 9'b0_0000_1000,
		S_PFX_ADD = 9'b0_0001_0000,
		S_MUL     = 9'b0_0010_0000,
		S_MUL_TOP = 9'b0_0100_0000,
		S_SCAN    = 9'b0_1000_0000,
		S_DONE    = 9'b1_0000_0000
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       count_q;
	logic                   ready_q;
	logic [FIT_W-1:0]       lo_q;
	logic [CNT_W-1:0]       idx_q;
	logic                   rd_vld_q;
	logic [MCNT_W-1:0]      mcnt_q;
	logic                   found_q;
	logic                   out_valid_q;

	logic [PFX_W-1:0]       acc_q;
	logic [FIT_W-1:0]       diff_q;
	logic [FRAC_W-1:0]      r_q;
	logic [OUT_IDX_W-1:0]   out_idx_q;
	logic                   out_found_q;

	// fitness store and running-sum store, registered reads
	logic [FIT_W-1:0]       fit_mem [POP_MAX];
	logic [FIT_W-1:0]       fit_rd_q;
	logic [PFX_W-1:0]       pfx_mem [POP_MAX];
	logic [PFX_W-1:0]       pfx_rd_q;

	logic                   in_acc;
	logic                   load_go;
	logic                   draw_go;
	logic [CNT_W-1:0]       base_cnt;
	logic                   load_room;
	logic [CNT_W-1:0]       idx_nxt;
	logic [CNT_W-1:0]       last_idx;
	logic                   last_ent;
	logic                   out_free;
	logic                   scan_hit;
	logic [FRAC_W-1:0]      r_sat;

	logic                   fit_re;
	logic [IDX_W-1:0]       fit_raddr;
	logic                   pfx_re;
	logic [IDX_W-1:0]       pfx_raddr;

	alu_req_t               alu_req;
	logic [ALU_W-1:0]       alu_res;

	// handshake and bookkeeping
	assign in_acc    = in_valid && (state_q == S_IDLE);
	assign load_go   = in_acc && (operation == OP_LOAD);
	assign draw_go   = in_acc && (operation == OP_DRAW);
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	// a load after a closed population starts over at entry zero
	assign base_cnt  = ready_q ? '0 : count_q;
	assign load_room = (base_cnt < CNT_W'(POP_MAX));

	assign idx_nxt   = idx_q + CNT_W'(1);
	assign last_idx  = count_q - CNT_W'(1);
	assign last_ent  = (idx_q == last_idx);
	assign scan_hit  = !alu_res[ALU_W-1];
	assign r_sat     = (random_fraction > FRAC_ONE) ? FRAC_ONE : random_fraction;

	// read port steering
	always_comb begin
		fit_re    = 1'b0;
		fit_raddr = idx_q[IDX_W-1:0];
		pfx_re    = 1'b0;
		pfx_raddr = idx_q[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				// fetch the total for a draw
				pfx_re    = draw_go && ready_q;
				pfx_raddr = last_idx[IDX_W-1:0];
			end
			S_MIN: begin
				fit_re = (idx_q < count_q);
			end
			S_PFX_RD: begin
				fit_re = 1'b1;
			end
			S_PFX_ADD: begin
				fit_re    = !last_ent;
				fit_raddr = idx_nxt[IDX_W-1:0];
			end
			S_MUL_TOP: begin
				pfx_re    = 1'b1;
				pfx_raddr = '0;
			end
			S_SCAN: begin
				pfx_re    = !(scan_hit || last_ent);
				pfx_raddr = idx_nxt[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// operands for the shared adder
	always_comb begin
		alu_req = '0;
		unique case (state_q)
			S_MIN, S_PFX_SUB: begin
				// fitness - minimum, sign tells which is smaller
				alu_req.a     = sext_fit(fit_rd_q);
				alu_req.b     = sext_fit(lo_q);
				alu_req.inv_b = 1'b1;
				alu_req.cin   = 1'b1;
			end
			S_PFX_ADD: begin
				alu_req.a   = ALU_W'(acc_q);
				alu_req.b   = ALU_W'(diff_q);
				alu_req.cin = WEIGHT_LSB;
			end
			S_MUL, S_MUL_TOP: begin
				alu_req.a = ALU_W'(acc_q);
				alu_req.b = r_q[0] ? ALU_W'(pfx_rd_q) : '0;
			end
			S_SCAN: begin
				// running sum - threshold, non-negative means hit
				alu_req.a     = ALU_W'(pfx_rd_q);
				alu_req.b     = ALU_W'(acc_q);
				alu_req.inv_b = 1'b1;
				alu_req.cin   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	rws_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	// memories
	always_ff @(posedge clk) begin
		if (load_go && load_room) begin
			fit_mem[base_cnt[IDX_W-1:0]] <= fitness;
		end
		if (fit_re) begin
			fit_rd_q <= fit_mem[fit_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PFX_ADD) begin
			pfx_mem[idx_q[IDX_W-1:0]] <= alu_res[PFX_W-1:0];
		end
		if (pfx_re) begin
			pfx_rd_q <= pfx_mem[pfx_raddr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ready_q     <= 1'b0;
			lo_q        <= '0;
			idx_q       <= '0;
			rd_vld_q    <= 1'b0;
			mcnt_q      <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (load_go) begin
						ready_q <= 1'b0;
						count_q <= load_room ? (base_cnt + CNT_W'(1)) : base_cnt;
						if (last) begin
							// close: seed the minimum search
							state_q  <= S_MIN;
							idx_q    <= '0;
							rd_vld_q <= 1'b0;
							lo_q     <= FIT_MAX;
						end
					end else if (draw_go) begin
						idx_q <= '0;
						if (ready_q) begin
							mcnt_q  <= '0;
							state_q <= S_MUL;
						end else begin
							found_q <= 1'b0;
							state_q <= S_DONE;
						end
					end
				end
				S_MIN: begin
					rd_vld_q <= fit_re;
					if (fit_re) begin
						idx_q <= idx_nxt;
					end
					if (rd_vld_q && alu_res[ALU_W-1]) begin
						lo_q <= fit_rd_q;
					end
					// the entry just returned was the last one issued
					if (rd_vld_q && (idx_q == count_q)) begin
						idx_q   <= '0;
						state_q <= S_PFX_RD;
					end
				end
				S_PFX_RD: begin
					state_q <= S_PFX_SUB;
				end
				S_PFX_SUB: begin
					state_q <= S_PFX_ADD;
				end
				S_PFX_ADD: begin
					if (last_ent) begin
						ready_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_nxt;
						state_q <= S_PFX_SUB;
					end
				end
				S_MUL: begin
					mcnt_q <= mcnt_q + MCNT_W'(1);
					if (mcnt_q == MCNT_W'(MUL_STEPS - 1)) begin
						state_q <= S_MUL_TOP;
					end
				end
				S_MUL_TOP: begin
					idx_q   <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_hit || last_ent) begin
						found_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_nxt;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// result register: load on completion, drop once taken
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (draw_go) begin
					r_q   <= r_sat;
					acc_q <= '0;
				end else if (load_go) begin
					acc_q <= '0;
				end
			end
			S_PFX_SUB: begin
				diff_q <= alu_res[FIT_W-1:0];
			end
			S_PFX_ADD: begin
				acc_q <= alu_res[PFX_W-1:0];
			end
			S_MUL: begin
				// advance one fraction bit, drop the low product bit
				acc_q <= alu_res[ALU_W-1:1];
				r_q   <= r_q >> 1;
			end
			S_MUL_TOP: begin
				// top fraction bit weighs a full total
				acc_q <= alu_res[PFX_W-1:0];
			end
			S_DONE: begin
				if (out_free) begin
					out_idx_q   <= OUT_IDX_W'(idx_q);
					out_found_q <= found_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign chosen_index = out_idx_q;
	assign found        = out_found_q;

	// checks
	a_ready_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> (count_q != '0))
		else $error("closed population with no entries");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(POP_MAX))
		else $error("population count past capacity");

	a_close_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(load_go && last) |=> (state_q == S_MIN))
		else $error("closing load did not start the minimum search");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (ready_q && (idx_q < count_q)))
		else $error("scan outside the closed population");

	a_done_posts: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && out_free) |=> (out_valid && (found == $past(found_q))))
		else $error("finished draw not posted to the output");

endmodule

>>> hdl/rws_alu.sv
// Shared adder/subtractor of the roulette wheel selector.
// Depends on rws_pkg for the operand width and the request struct.
`timescale 1ns / 1ps

module rws_alu import rws_pkg::*; (
	input  alu_req_t         req,
	output logic [ALU_W-1:0] res
);

	logic [ALU_W-1:0] b_eff;

	assign b_eff = req.inv_b ? ~req.b : req.b;
	assign res   = req.a + b_eff + ALU_W'(req.cin);

endmodule
